// ===== hw/rtl/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared widths, register indexes and shared-unit types of the flow-shop
// sequencer.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int TIME_W      = 16;
  localparam int SPAN_W      = 25;
  localparam int JOB_CFG_W   = 6;
  localparam int MACH_CFG_W  = 5;
  localparam int OUT_JOB_W   = 5;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MACHINE_COUNT = CFG_IDX_W'(1);

  // shared unit request: res = sat(max(a, b) + c), lt = (a < b)
  typedef struct packed {
    logic [SPAN_W-1:0] a;
    logic [SPAN_W-1:0] b;
    logic [SPAN_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [SPAN_W-1:0] res;
    logic              lt;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/fsc_ram.sv =====
// ----------------------------------------------------------------------------
// fsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fsc_alu.sv =====
// ----------------------------------------------------------------------------
// fsc_alu
// Shared arithmetic unit: max, saturating add and less-than compare.
// ----------------------------------------------------------------------------
module fsc_alu (
  input  fsc_pkg::alu_req_t req,
  output fsc_pkg::alu_rsp_t rsp
);
  import fsc_pkg::*;

  logic [SPAN_W-1:0] mx;
  logic [SPAN_W:0]   sum;

  assign mx      = (req.a < req.b) ? req.b : req.a;
  assign sum     = {1'b0, mx} + {1'b0, req.c};
  assign rsp.res = sum[SPAN_W] ? SPAN_MAX : sum[SPAN_W-1:0];
  assign rsp.lt  = (req.a < req.b);

endmodule

// ===== hw/rtl/flow_shop_cds_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// flow_shop_cds_sequencer_top
// Campbell-Dudek-Smith flow-shop sequencer: loads a job-by-machine time
// table, runs the heuristic on a shared unit and emits the best job order.
// ----------------------------------------------------------------------------
// Usage: write job_count (index 0) and machine_count (index 1) while idle
// with start low; each write restarts the table load. Then send nj*nm times,
// row-major, one transaction per cycle while busy is low. The transaction
// carrying the last time starts the heuristic and busy rises. For nj jobs
// and nm machines the run tries nm-1 candidates, each with a head/tail sum
// update per job and side (a read, then a write through the shared unit),
// a Johnson pass of nj scans over the 2*nj surrogate sums (one sums-RAM
// read per cycle), and a makespan pass that reads each table entry and
// updates the ready times through the shared unit.
// Results then come out one per cycle, out_valid high for exactly one cycle
// each; the receiver cannot stall, so it must take every result as shown.
// ----------------------------------------------------------------------------
module flow_shop_cds_sequencer_top #(
  parameter int MAX_JOBS     = 32,
  parameter int MAX_MACHINES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         start,
  output logic                         busy,
  input  logic [fsc_pkg::TIME_W-1:0]   in_proc_time,
  // result channel
  output logic                         out_valid,
  output logic [fsc_pkg::OUT_JOB_W-1:0] out_job_index,
  output logic [fsc_pkg::SPAN_W-1:0]   out_best_makespan,
  output logic                         out_final_job,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fsc_pkg::*;

  localparam int JW     = $clog2(MAX_JOBS);
  localparam int JCW    = $clog2(MAX_JOBS + 1);
  localparam int MW     = $clog2(MAX_MACHINES);
  localparam int MCW    = $clog2(MAX_MACHINES + 1);
  localparam int TDEPTH = MAX_JOBS * MAX_MACHINES;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int TCW    = $clog2(TDEPTH + 1);
  localparam int SUM_W  = TIME_W + MCW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SUM_RD  = 4'd1;
  localparam logic [3:0] S_SUM_WR  = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_PLACE   = 4'd4;
  localparam logic [3:0] S_MS_JOB  = 4'd5;
  localparam logic [3:0] S_MS_BASE = 4'd6;
  localparam logic [3:0] S_MS_RD   = 4'd7;
  localparam logic [3:0] S_MS_WR   = 4'd8;
  localparam logic [3:0] S_CMP     = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;

  // control state
  logic [3:0]            state_r, state_nxt;
  logic [TCW-1:0]        lp_r, lp_nxt;
  logic [JOB_CFG_W-1:0]  job_count_r, job_count_nxt;
  logic [MACH_CFG_W-1:0] mach_count_r, mach_count_nxt;
  logic [SPAN_W-1:0]     best_span_r, best_span_nxt;
  logic                  best_sel_r, best_sel_nxt;
  logic [MAX_JOBS-1:0]   taken_r, taken_nxt;
  logic                  vld_d_r, vld_d_nxt;
  logic                  last_d_r, last_d_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  found_r, found_nxt;

  // loop counters and work registers
  logic [MW-1:0]         k_r, k_nxt;
  logic [JCW-1:0]        j_r, j_nxt;
  logic                  side_r, side_nxt;
  logic [TAW-1:0]        row_base_r, row_base_nxt;
  logic [JCW:0]          s_r, s_nxt;
  logic [JW:0]           rd_idx_r, rd_idx_nxt;
  logic [SUM_W-1:0]      best_r, best_nxt;
  logic [JW-1:0]         bx_r, bx_nxt;
  logic                  by_r, by_nxt;
  logic [JCW-1:0]        front_r, front_nxt;
  logic [JCW-1:0]        back_r, back_nxt;
  logic [JCW-1:0]        it_r, it_nxt;
  logic [JCW-1:0]        pos_r, pos_nxt;
  logic [MW-1:0]         mi_r, mi_nxt;
  logic [TAW-1:0]        base_r, base_nxt;
  logic [SPAN_W-1:0]     prev_r, prev_nxt;
  logic [SPAN_W-1:0]     span_r, span_nxt;
  logic [JCW-1:0]        e_r, e_nxt;

  // effective sizes
  logic [JCW-1:0]        nj;
  logic [MCW-1:0]        nm;
  logic [TCW-1:0]        total;
  logic [TCW-1:0]        lp_eff;

  // memory ports
  logic                  t_we;
  logic [TAW-1:0]        t_waddr, t_raddr;
  logic [TIME_W-1:0]     t_rdata;
  logic                  s_we;
  logic [JW:0]           s_waddr, s_raddr;
  logic [SUM_W-1:0]      s_wdata, s_rdata;
  logic                  o_we;
  logic [JW:0]           o_waddr, o_raddr;
  logic [JW-1:0]         o_wdata, o_rdata;
  logic                  m_we;
  logic [MW-1:0]         m_waddr, m_raddr;
  logic [SPAN_W-1:0]     m_wdata, m_rdata;

  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  logic [JW-1:0]         scan_job;
  logic [JCW-1:0]        back_dec;

  always_comb begin
    if (job_count_r == '0) begin
      nj = JCW'(1);
    end else if (int'(job_count_r) > MAX_JOBS) begin
      nj = JCW'(MAX_JOBS);
    end else begin
      nj = JCW'(job_count_r);
    end
    if (int'(mach_count_r) < 2) begin
      nm = MCW'(2);
    end else if (int'(mach_count_r) > MAX_MACHINES) begin
      nm = MCW'(MAX_MACHINES);
    end else begin
      nm = MCW'(mach_count_r);
    end
  end

  assign total  = TCW'(nj * nm);
  assign lp_eff = (lp_r >= total) ? '0 : lp_r;

  assign busy      = (state_r != S_IDLE);
  // a time transaction offered in the same cycle goes first
  assign cfg_ready = !busy && !start;

  assign scan_job = rd_idx_r[JW:1];
  assign back_dec = back_r - JCW'(1);

  fsc_ram #(.WIDTH(TIME_W), .DEPTH(TDEPTH)) u_time_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(in_proc_time),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  fsc_ram #(.WIDTH(SUM_W), .DEPTH(2 * MAX_JOBS)) u_sum_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // two order buffers: best_sel_r picks the best one, the other is the candidate
  fsc_ram #(.WIDTH(JW), .DEPTH(2 * (1 << JW))) u_order_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  fsc_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_MACHINES)) u_ready_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  fsc_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    lp_nxt         = lp_r;
    job_count_nxt  = job_count_r;
    mach_count_nxt = mach_count_r;
    best_span_nxt  = best_span_r;
    best_sel_nxt   = best_sel_r;
    taken_nxt      = taken_r;
    vld_d_nxt      = 1'b0;
    last_d_nxt     = last_d_r;
    rd_vld_nxt     = rd_vld_r;
    found_nxt      = found_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    side_nxt       = side_r;
    row_base_nxt   = row_base_r;
    s_nxt          = s_r;
    rd_idx_nxt     = rd_idx_r;
    best_nxt       = best_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    it_nxt         = it_r;
    pos_nxt        = pos_r;
    mi_nxt         = mi_r;
    base_nxt       = base_r;
    prev_nxt       = prev_r;
    span_nxt       = span_r;
    e_nxt          = e_r;

    t_we    = 1'b0;
    t_waddr = lp_eff[TAW-1:0];
    t_raddr = '0;
    s_we    = 1'b0;
    s_waddr = {j_r[JW-1:0], side_r};
    s_wdata = alu_rsp.res[SUM_W-1:0];
    s_raddr = {j_r[JW-1:0], side_r};
    o_we    = 1'b0;
    o_waddr = '0;
    o_wdata = bx_r;
    o_raddr = '0;
    m_we    = 1'b0;
    m_waddr = mi_r;
    m_wdata = alu_rsp.res;
    m_raddr = mi_r;
    alu_req = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          unique case (cfg_index)
            REG_JOB_COUNT: begin
              job_count_nxt = cfg_data[JOB_CFG_W-1:0];
              lp_nxt        = '0;
            end
            REG_MACHINE_COUNT: begin
              mach_count_nxt = cfg_data[MACH_CFG_W-1:0];
              lp_nxt         = '0;
            end
            default: ;
          endcase
        end else if (start) begin
          t_we = 1'b1;
          if (lp_eff + TCW'(1) == total) begin
            lp_nxt        = '0;
            k_nxt         = '0;
            j_nxt         = '0;
            side_nxt      = 1'b0;
            row_base_nxt  = '0;
            best_span_nxt = SPAN_MAX;
            state_nxt     = S_SUM_RD;
          end else begin
            lp_nxt = lp_eff + TCW'(1);
          end
        end
      end

      // head sum adds column k, tail sum adds column nm-1-k
      S_SUM_RD: begin
        if (side_r) begin
          t_raddr = row_base_r + TAW'(nm) - TAW'(1) - TAW'(k_r);
        end else begin
          t_raddr = row_base_r + TAW'(k_r);
        end
        state_nxt = S_SUM_WR;
      end

      S_SUM_WR: begin
        alu_req.a = (k_r == '0) ? '0 : SPAN_W'(s_rdata);
        alu_req.c = SPAN_W'(t_rdata);
        s_we      = 1'b1;
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_SUM_RD;
        end else begin
          side_nxt     = 1'b0;
          j_nxt        = j_r + JCW'(1);
          row_base_nxt = row_base_r + TAW'(nm);
          if (j_r + JCW'(1) == nj) begin
            taken_nxt  = '0;
            front_nxt  = '0;
            back_nxt   = nj;
            it_nxt     = '0;
            s_nxt      = '0;
            rd_vld_nxt = 1'b0;
            found_nxt  = 1'b0;
            state_nxt  = S_SCAN;
          end else begin
            state_nxt = S_SUM_RD;
          end
        end
      end

      // one sums read issued per cycle, evaluated the cycle after
      S_SCAN: begin
        s_raddr = s_r[JW:0];
        if (s_r < {nj, 1'b0}) begin
          s_nxt      = s_r + (JCW+1)'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = s_r[JW:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        alu_req.a = SPAN_W'(s_rdata);
        alu_req.b = SPAN_W'(best_r);
        if (rd_vld_r) begin
          if (!taken_r[scan_job] && (!found_r || alu_rsp.lt)) begin
            best_nxt  = s_rdata;
            bx_nxt    = scan_job;
            by_nxt    = rd_idx_r[0];
            found_nxt = 1'b1;
          end
          if ((JCW+1)'(rd_idx_r) + (JCW+1)'(1) == {nj, 1'b0}) begin
            rd_vld_nxt = 1'b0;
            state_nxt  = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        o_we = 1'b1;
        if (!by_r) begin
          o_waddr   = {~best_sel_r, front_r[JW-1:0]};
          front_nxt = front_r + JCW'(1);
        end else begin
          o_waddr  = {~best_sel_r, back_dec[JW-1:0]};
          back_nxt = back_dec;
        end
        taken_nxt[bx_r] = 1'b1;
        found_nxt       = 1'b0;
        it_nxt          = it_r + JCW'(1);
        if (it_r + JCW'(1) == nj) begin
          pos_nxt   = '0;
          state_nxt = S_MS_JOB;
        end else begin
          s_nxt      = '0;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_MS_JOB: begin
        o_raddr   = {~best_sel_r, pos_r[JW-1:0]};
        state_nxt = S_MS_BASE;
      end

      S_MS_BASE: begin
        base_nxt  = TAW'(o_rdata * nm);
        mi_nxt    = '0;
        state_nxt = S_MS_RD;
      end

      S_MS_RD: begin
        t_raddr   = base_r + TAW'(mi_r);
        state_nxt = S_MS_WR;
      end

      // ready[mi] = sat(max(ready[mi-1], ready[mi]) + t)
      S_MS_WR: begin
        alu_req.a = (mi_r == '0) ? '0 : prev_r;
        alu_req.b = (pos_r == '0) ? '0 : m_rdata;
        alu_req.c = SPAN_W'(t_rdata);
        m_we      = 1'b1;
        prev_nxt  = alu_rsp.res;
        if (MCW'(mi_r) + MCW'(1) == nm) begin
          span_nxt = alu_rsp.res;
          pos_nxt  = pos_r + JCW'(1);
          if (pos_r + JCW'(1) == nj) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_MS_JOB;
          end
        end else begin
          mi_nxt    = mi_r + MW'(1);
          state_nxt = S_MS_RD;
        end
      end

      S_CMP: begin
        alu_req.a = span_r;
        alu_req.b = best_span_r;
        if (k_r == '0 || alu_rsp.lt) begin
          best_span_nxt = span_r;
          best_sel_nxt  = ~best_sel_r;
        end
        if (MCW'(k_r) + MCW'(2) == nm) begin
          e_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt        = k_r + MW'(1);
          j_nxt        = '0;
          side_nxt     = 1'b0;
          row_base_nxt = '0;
          state_nxt    = S_SUM_RD;
        end
      end

      S_EMIT: begin
        o_raddr    = {best_sel_r, e_r[JW-1:0]};
        vld_d_nxt  = 1'b1;
        last_d_nxt = (e_r + JCW'(1) == nj);
        e_nxt      = e_r + JCW'(1);
        if (e_r + JCW'(1) == nj) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lp_r         <= '0;
      job_count_r  <= JOB_CFG_W'(1);
      mach_count_r <= MACH_CFG_W'(2);
      best_span_r  <= SPAN_MAX;
      best_sel_r   <= 1'b0;
      taken_r      <= '0;
      vld_d_r      <= 1'b0;
      last_d_r     <= 1'b0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lp_r         <= lp_nxt;
      job_count_r  <= job_count_nxt;
      mach_count_r <= mach_count_nxt;
      best_span_r  <= best_span_nxt;
      best_sel_r   <= best_sel_nxt;
      taken_r      <= taken_nxt;
      vld_d_r      <= vld_d_nxt;
      last_d_r     <= last_d_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    side_r     <= side_nxt;
    row_base_r <= row_base_nxt;
    s_r        <= s_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    it_r       <= it_nxt;
    pos_r      <= pos_nxt;
    mi_r       <= mi_nxt;
    base_r     <= base_nxt;
    prev_r     <= prev_nxt;
    span_r     <= span_nxt;
    e_r        <= e_nxt;
  end

  // order RAM read data lands the cycle after each emit read
  assign out_valid         = vld_d_r;
  assign out_job_index     = OUT_JOB_W'(o_rdata);
  assign out_best_makespan = best_span_r;
  assign out_final_job     = vld_d_r & last_d_r;

endmodule
